FILE: hw/rtl/wilder_rsi_indicator_top_defines.svh
// Assertion macros for the RSI indicator block.
// Included by wilder_rsi_indicator_top, which carries the concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef WILDER_RSI_INDICATOR_TOP_DEFINES_SVH
`define WILDER_RSI_INDICATOR_TOP_DEFINES_SVH

// Base form: a property checked on every rising clock edge outside reset.
`define WRSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same-cycle implication.
`define WRSI_ASSERT_NOW(label, ante, cons, msg) \
    `WRSI_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define WRSI_ASSERT_NEXT(label, ante, cons, msg) \
    `WRSI_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: hw/rtl/wrsi_pkg.sv
// Package for the RSI indicator block: widths, constants, request types and sequencer states.
// Has no dependencies; imported by wilder_rsi_indicator_top and its testbench.
`default_nettype none

package wrsi_pkg;

    localparam int unsigned PERIOD_DEF = 14;
    localparam int unsigned PRICE_W    = 32;
    localparam int unsigned AVG_W      = 48;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned RSI_W      = 15;
    localparam int unsigned RSI_FULL   = 25600;

    typedef struct packed {
        logic [PRICE_W-1:0] close_price;
        logic               window_start;
    } t_in_req;

    typedef struct packed {
        logic [RSI_W-1:0] rsi_value;
        logic             rsi_valid;
    } t_out_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_PREP_G,
        S_DIV_G,
        S_SAVE_G,
        S_PREP_L,
        S_DIV_L,
        S_SAVE_L,
        S_RESULT,
        S_DIV_R,
        S_SAVE_R,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/wilder_rsi_indicator_top.sv
// Top level of the Wilder RSI indicator: sequencer, state registers and one shared divider.
// Depends on wrsi_pkg and on wilder_rsi_indicator_top_defines.svh for its assertions.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+----------------------------------
//   input   | in        | i_in_valid / o_in_stall    | i_in_req  (close_price, window_start)
//   output  | out       | o_out_valid / i_out_stall  | o_out_req (rsi_value, rsi_valid)
//
// Every request yields exactly one result. A window start goes from acceptance straight to
// S_DONE, and a request during the first PERIOD-1 changes passes only S_UPDATE and S_RESULT.
// Once averages exist, each average is divided by PERIOD in three 16-bit digit steps by
// reciprocal multiplication, and the restoring divider resolves the 15 bits of the final
// ratio one per cycle. With a zero loss average the ratio is skipped.
// Reset is synchronous and active low; it clears the history to zero, as on power up.
// o_in_stall is high whenever the sequencer is not idle, also while a finished result waits
// for the output register; once it is there, the next request can be taken while it stalls.
`default_nettype none

module wilder_rsi_indicator_top #(
    parameter int unsigned PERIOD = wrsi_pkg::PERIOD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire wrsi_pkg::t_in_req i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output wrsi_pkg::t_out_req     o_out_req
);

    import wrsi_pkg::*;

`include "wilder_rsi_indicator_top_defines.svh"

    // Change counter holds 0..PERIOD. Smoothing dividends are below PERIOD * 2^48, so the
    // upper CNT_W bits seed the remainder. The ratio numerator 25600*avg fits AVG_W+RSI_W.
    localparam int unsigned CNT_W  = $clog2(PERIOD + 1);
    localparam int unsigned DVD_W  = AVG_W + CNT_W;
    localparam int unsigned NUM_W  = AVG_W + RSI_W;
    localparam int unsigned DIVR_W = AVG_W + 1;
    localparam int unsigned QCNT_W = $clog2(AVG_W + 1);

    // Division by PERIOD works on 16-bit digits. A digit step divides {remainder, digit},
    // which is below PERIOD * 2^16, by multiplying with floor(2^RCP_SH / PERIOD). The
    // estimate is at most one short, and one compare and subtract corrects it.
    localparam int unsigned DIGIT_W = 16;
    localparam int unsigned DIGITS  = AVG_W / DIGIT_W;
    localparam int unsigned CV_W    = CNT_W + DIGIT_W;
    localparam int unsigned RCP_SH  = CV_W + 2;
    localparam int unsigned CP_W    = CV_W + RCP_SH;
    localparam int unsigned RCP_M   = (1 << RCP_SH) / PERIOD;

    // Sequencer and history state.
    t_state               r_state, n_state;
    logic [PRICE_W-1:0]   r_prev, n_prev;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [AVG_W-1:0]     r_avg_g, n_avg_g;
    logic [AVG_W-1:0]     r_avg_l, n_avg_l;
    logic [PRICE_W-1:0]   r_gain, n_gain;
    logic [PRICE_W-1:0]   r_loss, n_loss;
    logic                 r_smooth, n_smooth;

    // Shared divider: remainder, pending dividend bits, quotient, divisor, step count.
    logic [DIVR_W-1:0]    r_rem, n_rem;
    logic [AVG_W-1:0]     r_low, n_low;
    logic [AVG_W-1:0]     r_quo, n_quo;
    logic [DIVR_W-1:0]    r_div, n_div;
    logic [QCNT_W-1:0]    r_qcnt, n_qcnt;

    // Result waiting for the output register, and the output register itself.
    t_out_req             r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    t_out_req             r_out_req, n_out_req;

    logic                 w_accept;
    logic                 w_out_free;
    logic [CNT_W-1:0]     w_count_inc;
    logic                 w_fill_done;
    logic [AVG_W-1:0]     w_avg_sel;
    logic [PRICE_W-1:0]   w_new_sel;
    logic [DVD_W-1:0]     w_dvd;
    logic [NUM_W-1:0]     w_num;
    logic [DIVR_W:0]      w_trial;
    logic [DIVR_W:0]      w_diff;
    logic                 w_ge;
    logic                 w_last_bit;
    logic [CV_W-1:0]      w_cv;
    logic [CP_W-1:0]      w_cprod;
    logic [DIGIT_W-1:0]   w_cq_est;
    logic [CV_W-1:0]      w_cback;
    logic [CV_W-1:0]      w_crem;
    logic                 w_cfix;
    logic [DIGIT_W-1:0]   w_cdigit;
    logic [CV_W-1:0]      w_crem_next;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    assign w_count_inc = r_count + CNT_W'(1);
    assign w_fill_done = (w_count_inc == CNT_W'(PERIOD));

    // The smoothing dividend is avg*(PERIOD-1) + (new << 16); right after the fill phase the
    // average register still holds the plain sum, and the dividend is the sum shifted up.
    assign w_avg_sel = (r_state == S_PREP_L) ? r_avg_l : r_avg_g;
    assign w_new_sel = (r_state == S_PREP_L) ? r_loss  : r_gain;

    always_comb begin
        if (r_smooth) begin
            w_dvd = ({{CNT_W{1'b0}}, w_avg_sel} * DVD_W'(PERIOD - 1))
                  + DVD_W'({w_new_sel, {FRAC_W{1'b0}}});
        end else begin
            w_dvd = DVD_W'({w_avg_sel, {FRAC_W{1'b0}}});
        end
    end

    assign w_num = {{RSI_W{1'b0}}, r_avg_g} * NUM_W'(RSI_FULL);

    // One quotient digit per cycle when dividing by PERIOD.
    assign w_cv        = {r_rem[CNT_W-1:0], r_low[AVG_W-1 -: DIGIT_W]};
    assign w_cprod     = {{RCP_SH{1'b0}}, w_cv} * CP_W'(RCP_M);
    assign w_cq_est    = w_cprod[RCP_SH +: DIGIT_W];
    assign w_cback     = {{CNT_W{1'b0}}, w_cq_est} * CV_W'(PERIOD);
    assign w_crem      = w_cv - w_cback;
    assign w_cfix      = (w_crem >= CV_W'(PERIOD));
    assign w_cdigit    = w_cq_est + DIGIT_W'(w_cfix);
    assign w_crem_next = w_cfix ? (w_crem - CV_W'(PERIOD)) : w_crem;

    // One quotient bit per cycle for the ratio: shift in the next bit, subtract if it fits.
    assign w_trial    = {r_rem, r_low[AVG_W-1]};
    assign w_diff     = w_trial - {1'b0, r_div};
    assign w_ge       = (w_trial >= {1'b0, r_div});
    assign w_last_bit = (r_qcnt == QCNT_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_in_req.window_start ? S_DONE : S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_count < CNT_W'(PERIOD)) begin
                    n_state = w_fill_done ? S_PREP_G : S_RESULT;
                end else begin
                    n_state = S_PREP_G;
                end
            end
            S_PREP_G: n_state = S_DIV_G;
            S_DIV_G: begin
                if (w_last_bit) begin
                    n_state = S_SAVE_G;
                end
            end
            S_SAVE_G: n_state = S_PREP_L;
            S_PREP_L: n_state = S_DIV_L;
            S_DIV_L: begin
                if (w_last_bit) begin
                    n_state = S_SAVE_L;
                end
            end
            S_SAVE_L: n_state = S_RESULT;
            S_RESULT: begin
                if ((r_count < CNT_W'(PERIOD)) || (r_avg_l == '0)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV_R;
                end
            end
            S_DIV_R: begin
                if (w_last_bit) begin
                    n_state = S_SAVE_R;
                end
            end
            S_SAVE_R: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and output register next values.
    always_comb begin
        n_prev      = r_prev;
        n_count     = r_count;
        n_avg_g     = r_avg_g;
        n_avg_l     = r_avg_l;
        n_gain      = r_gain;
        n_loss      = r_loss;
        n_smooth    = r_smooth;
        n_rem       = r_rem;
        n_low       = r_low;
        n_quo       = r_quo;
        n_div       = r_div;
        n_qcnt      = r_qcnt;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_req   = r_out_req;

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_prev = i_in_req.close_price;
                    if (i_in_req.window_start) begin
                        n_count = '0;
                        n_avg_g = '0;
                        n_avg_l = '0;
                        n_res   = '0;
                    end else if (i_in_req.close_price > r_prev) begin
                        n_gain = i_in_req.close_price - r_prev;
                        n_loss = '0;
                    end else begin
                        n_gain = '0;
                        n_loss = r_prev - i_in_req.close_price;
                    end
                end
            end
            S_UPDATE: begin
                if (r_count < CNT_W'(PERIOD)) begin
                    n_avg_g  = r_avg_g + AVG_W'(r_gain);
                    n_avg_l  = r_avg_l + AVG_W'(r_loss);
                    n_count  = w_count_inc;
                    n_smooth = 1'b0;
                end else begin
                    n_smooth = 1'b1;
                end
            end
            S_PREP_G, S_PREP_L: begin
                n_rem  = DIVR_W'(w_dvd[DVD_W-1:AVG_W]);
                n_low  = w_dvd[AVG_W-1:0];
                n_div  = DIVR_W'(PERIOD);
                n_qcnt = QCNT_W'(DIGITS);
            end
            S_DIV_G, S_DIV_L: begin
                n_rem  = DIVR_W'(w_crem_next[CNT_W-1:0]);
                n_low  = {r_low[AVG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                n_quo  = {r_quo[AVG_W-DIGIT_W-1:0], w_cdigit};
                n_qcnt = r_qcnt - QCNT_W'(1);
            end
            S_DIV_R: begin
                n_rem  = w_ge ? w_diff[DIVR_W-1:0] : w_trial[DIVR_W-1:0];
                n_low  = {r_low[AVG_W-2:0], 1'b0};
                n_quo  = {r_quo[AVG_W-2:0], w_ge};
                n_qcnt = r_qcnt - QCNT_W'(1);
            end
            S_SAVE_G: n_avg_g = r_quo;
            S_SAVE_L: n_avg_l = r_quo;
            S_RESULT: begin
                if (r_count < CNT_W'(PERIOD)) begin
                    n_res = '0;
                end else if (r_avg_l == '0) begin
                    // No losses at all, flat prices included, read as full strength.
                    n_res.rsi_value = RSI_W'(RSI_FULL);
                    n_res.rsi_valid = 1'b1;
                end else begin
                    n_rem  = DIVR_W'(w_num[NUM_W-1:RSI_W]);
                    n_low  = {w_num[RSI_W-1:0], {(AVG_W-RSI_W){1'b0}}};
                    n_div  = {1'b0, r_avg_g} + {1'b0, r_avg_l};
                    n_qcnt = QCNT_W'(RSI_W);
                end
            end
            S_SAVE_R: begin
                n_res.rsi_value = r_quo[RSI_W-1:0];
                n_res.rsi_valid = 1'b1;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_req   = r_res;
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_count     <= '0;
            r_avg_g     <= '0;
            r_avg_l     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_count     <= n_count;
            r_avg_g     <= n_avg_g;
            r_avg_l     <= n_avg_l;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gain    <= n_gain;
        r_loss    <= n_loss;
        r_smooth  <= n_smooth;
        r_rem     <= n_rem;
        r_low     <= n_low;
        r_quo     <= n_quo;
        r_div     <= n_div;
        r_qcnt    <= n_qcnt;
        r_res     <= n_res;
        r_out_req <= n_out_req;
    end

    // The divider is only ever seeded with a partial remainder below the divisor.
    `WRSI_ASSERT_NOW(a_rem_below_div,
        (r_state == S_DIV_G || r_state == S_DIV_L || r_state == S_DIV_R),
        (r_rem < r_div), "divider remainder not below divisor")

    // A finished result goes out as soon as the output register is free.
    `WRSI_ASSERT_NEXT(a_done_handoff, (r_state == S_DONE && w_out_free),
        (r_out_valid && r_state == S_IDLE), "result not handed to output register")

    // The index never exceeds full scale.
    `WRSI_ASSERT_NOW(a_rsi_range, r_out_valid,
        (r_out_req.rsi_value <= RSI_W'(RSI_FULL)), "rsi value above full scale")

    // A window start clears the change count.
    `WRSI_ASSERT_NEXT(a_window_clear, (w_accept && i_in_req.window_start),
        (r_count == '0 && r_state == S_DONE), "window start did not clear history")

endmodule

`default_nettype wire

FILE: sim/wilder_rsi_indicator_top_tb.sv
// Self-checking testbench for the Wilder RSI indicator: directed and random price streams.
// Depends on wrsi_pkg and wilder_rsi_indicator_top; an in-bench predictor checks every result.
`default_nettype none

module wilder_rsi_indicator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wrsi_pkg::*;

    localparam int unsigned RSI_PERIOD  = PERIOD_DEF;
    localparam int unsigned ITEM_GOAL   = 1900;
    // A smoothed request ends long before this limit, so a quiet run this long can only mean
    // the block has hung.
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES = 300;

    // Scoreboard: a bit-true predictor of the indicator and the queue of RSI results it owes.
    class rsi_scoreboard;
        logic [PRICE_W-1:0] last_price;
        int unsigned        changes;
        logic [AVG_W-1:0]   gain_avg;
        logic [AVG_W-1:0]   loss_avg;
        t_out_req           rsi_owed_q[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        valid_checked;

        function new();
            last_price    = '0;
            changes       = 0;
            gain_avg      = '0;
            loss_avg      = '0;
            errors        = 0;
            checked       = 0;
            valid_checked = 0;
        endfunction

        // The window sum is scaled to Q32.16 and divided by the period.
        function logic [AVG_W-1:0] seed_average(logic [AVG_W-1:0] sum);
            logic [63:0] wide;
            wide = {16'd0, sum} << FRAC_W;
            return AVG_W'(wide / RSI_PERIOD);
        endfunction

        function logic [AVG_W-1:0] smooth_average(logic [AVG_W-1:0] avg,
                                                  logic [PRICE_W-1:0] change);
            logic [63:0] acc;
            acc = {16'd0, avg} * 64'(RSI_PERIOD - 1) + ({32'd0, change} << FRAC_W);
            return AVG_W'(acc / RSI_PERIOD);
        endfunction

        function void note_request(t_in_req req);
            logic [PRICE_W-1:0] gain;
            logic [PRICE_W-1:0] loss;
            logic [63:0]        num;
            t_out_req           res;
            gain = '0;
            loss = '0;
            res  = '0;
            if (req.window_start) begin
                last_price = req.close_price;
                changes    = 0;
                gain_avg   = '0;
                loss_avg   = '0;
            end else begin
                if (req.close_price > last_price) begin
                    gain = req.close_price - last_price;
                end else begin
                    loss = last_price - req.close_price;
                end
                last_price = req.close_price;
                if (changes < RSI_PERIOD) begin
                    gain_avg = gain_avg + gain;
                    loss_avg = loss_avg + loss;
                    changes++;
                    if (changes == RSI_PERIOD) begin
                        gain_avg = seed_average(gain_avg);
                        loss_avg = seed_average(loss_avg);
                    end
                end else begin
                    gain_avg = smooth_average(gain_avg, gain);
                    loss_avg = smooth_average(loss_avg, loss);
                end
                if (changes >= RSI_PERIOD) begin
                    res.rsi_valid = 1'b1;
                    if (loss_avg == '0) begin
                        res.rsi_value = RSI_W'(RSI_FULL);
                    end else begin
                        num = 64'(RSI_FULL) * {16'd0, gain_avg};
                        res.rsi_value = RSI_W'(num / ({16'd0, gain_avg} + {16'd0, loss_avg}));
                    end
                end
            end
            rsi_owed_q = {rsi_owed_q, res};
        endfunction

        function void check_result(t_out_req got);
            t_out_req want;
            if (rsi_owed_q.size() == 0) begin
                $error("result with no request waiting: rsi_value %0d, rsi_valid %0b",
                       got.rsi_value, got.rsi_valid);
                errors++;
                return;
            end
            want = rsi_owed_q.pop_front();
            checked++;
            if (want.rsi_valid) valid_checked++;
            if (got.rsi_value !== want.rsi_value) begin
                $error("rsi_value: expected %0d, actual %0d", want.rsi_value, got.rsi_value);
                errors++;
            end
            if (got.rsi_valid !== want.rsi_valid) begin
                $error("rsi_valid: expected %0b, actual %0b", want.rsi_valid, got.rsi_valid);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return rsi_owed_q.size();
        endfunction
    endclass

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_stall;
    t_in_req  i_in_req    = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_out_req o_out_req;

    rsi_scoreboard board;
    // While calm is set neither side idles, giving one long stretch at full rate.
    bit            calm = 1'b0;
    int unsigned   sent = 0;
    int unsigned   starts_sent = 0;
    int unsigned   quiet_cycles = 0;

    wilder_rsi_indicator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The receiver stalls about a quarter of the time, except during the calm stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 25);
    end

    // Result monitor and watchdog counter. Values read here are those from before the edge,
    // since the block and the drivers only change them with nonblocking assignments.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                board.check_result(o_out_req);
            end
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Watchdog: a long run of cycles in which no request moves on either side ends the run.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $error("no request moved for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Offers one price request, with a random idle gap first unless the run is calm, and
    // holds it until the block takes it. The scoreboard learns of it at the accepting edge,
    // so the owed queue is up to date when this task returns.
    task automatic send_request(input logic [PRICE_W-1:0] price, input logic start);
        t_in_req req;
        req.close_price  = price;
        req.window_start = start;
        while (!calm && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        board.note_request(req);
        sent++;
        if (start) starts_sent++;
    endtask

    initial begin
        int unsigned        n;
        int unsigned        pick;
        int unsigned        up_pct;
        int unsigned        k;
        logic [PRICE_W-1:0] price;
        logic [PRICE_W-1:0] step;
        bit                 paused;
        paused = 1'b0;
        board  = new();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The very first price comes without a window start, so it is
        // measured against the zero price left by reset.
        send_request(32'd1000, 1'b0);
        // A flat window: both averages stay zero, and a zero loss average reads as full scale, 25600.
        send_request(32'd7, 1'b1);
        repeat (RSI_PERIOD) send_request(32'd7, 1'b0);
        // A drop with no gains at all gives an index of zero, then full-scale swings
        // push the largest possible gains and losses through the smoothing.
        send_request(32'd0, 1'b0);
        send_request('1, 1'b0);
        send_request(32'd0, 1'b0);
        send_request('1, 1'b0);
        // A window start in the middle of valid output drops the history at the top price.
        send_request('1, 1'b1);
        send_request(32'd1, 1'b0);

        // Random part: mostly whole windows with random content, some loose noise.
        while (sent < ITEM_GOAL) begin
            calm = (sent >= 700 && sent < 1000);
            if (!paused && sent >= 1300) begin
                // Let the block drain completely before going on.
                paused = 1'b1;
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (board.pending() != 0);
            end
            if ($urandom_range(99) < 80) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    n = $urandom_range(0, RSI_PERIOD - 1);
                end else if (pick < 85) begin
                    n = $urandom_range(RSI_PERIOD, 30);
                end else begin
                    n = $urandom_range(31, 60);
                end
                // Each window gets its own trend and step size, so the index spans its range.
                up_pct = $urandom_range(100);
                k      = $urandom_range(2, 31);
                price  = $urandom();
                send_request(price, 1'b1);
                for (int i = 0; i < n; i++) begin
                    pick = $urandom_range(9);
                    if (pick == 0) begin
                        price = $urandom();
                    end else if (pick != 1) begin
                        step = $urandom() & ((32'd1 << k) - 32'd1);
                        if ($urandom_range(99) < up_pct) begin
                            price = price + step;
                        end else begin
                            price = price - step;
                        end
                    end
                    send_request(price, 1'b0);
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_request($urandom(), $urandom_range(99) < 30);
                end
            end
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d price requests (%0d window starts); checked %0d results, %0d of them",
                 sent, starts_sent, board.checked, board.valid_checked);
        $display("with a valid index, under random idling, a calm stretch and one full drain.");
        if (board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
